// File: hdl/ctt_pkg.sv
`timescale 1ns / 1ps
// Package for the config text tokenizer: types, character codes and sizes.
// Used by every module of the block; has no dependencies of its own.

package ctt_pkg;

	// Source offset width; the position saturates at all ones.
	localparam int OFFSET_BITS = 24;
	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

	// Width of the start and length fields on the result side.
	localparam int FIELD_W = 24;

	// Token queue between scanner and output stage.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Character codes the scanner cares about.
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	typedef enum logic [2:0] {
		KIND_END         = 3'd0,
		KIND_IDENT       = 3'd1,
		KIND_BLOCK_OPEN  = 3'd2,
		KIND_BLOCK_CLOSE = 3'd3,
		KIND_LIST_OPEN   = 3'd4,
		KIND_LIST_CLOSE  = 3'd5,
		KIND_COLON       = 3'd6,
		KIND_COMMA       = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE     = 4'd0,
		MODE_DASH     = 4'd1,
		MODE_DASH2    = 4'd2,
		MODE_DASH2_BR = 4'd3,
		MODE_LINE     = 4'd4,
		MODE_BLOCK    = 4'd5,
		MODE_BLOCK_BR = 4'd6,
		MODE_IDENT    = 4'd7,
		MODE_STRING   = 4'd8,
		MODE_STR_ESC  = 4'd9
	} mode_t;

	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] len;
		logic               quoted;
	} tok_t;

	// All tokens caused by one input item.
	typedef struct packed {
		tok_t t0;
		tok_t t1;
		logic two;
		logic ovf;
	} rec_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: hdl/config_text_tokenizer.sv
`timescale 1ns / 1ps
// Tokenizer top level: one source byte (or end marker) accepted per cycle while
// full is low; the scanner mode machine settles each byte as it is taken.
// A token is written to the queue storage, then loaded into the output register
// that drives the result ports once it is free. Each item gives up to two tokens,
// handed out one per pop; full rises when the four-record queue is taken up.
// Reset (arst_n low, asynchronous) empties queue and output, mode idle, offset 0.

module config_text_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_value,
	input  logic        end_marker,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  token_kind,
	output logic [23:0] token_start,
	output logic [23:0] token_length,
	output logic        quoted,
	output logic        offset_overflow,
	output logic        last_of_run
);

	ctt_pkg::rec_t    wr_rec, rd_rec;
	ctt_pkg::q_stat_t stat;
	logic             take, wr_en, rd_en;

	assign full = stat.full;
	assign take = push && !stat.full;

	ctt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.byte_value (byte_value),
		.end_marker (end_marker),
		.rec_valid  (wr_en),
		.rec        (wr_rec)
	);

	ctt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_rec),
		.rd_en   (rd_en),
		.rd_data (rd_rec),
		.stat    (stat)
	);

	ctt_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rd_data         (rd_rec),
		.stat            (stat),
		.rd_en           (rd_en),
		.pop             (pop),
		.empty           (empty),
		.token_kind      (token_kind),
		.token_start     (token_start),
		.token_length    (token_length),
		.quoted          (quoted),
		.offset_overflow (offset_overflow),
		.last_of_run     (last_of_run)
	);

endmodule

// File: hdl/ctt_front.sv
`timescale 1ns / 1ps
// Scanner front end: classifies each source byte and runs the mode machine.
// Depends on ctt_pkg; emits one token record per item that yields tokens.

module ctt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          byte_value,
	input  logic                end_marker,
	output logic                rec_valid,
	output ctt_pkg::rec_t       rec
);

	ctt_pkg::mode_t                   mode_q, mode_d;
	logic [ctt_pkg::OFFSET_BITS-1:0]  pos_q, pend_q, pend_d, nxt, span;
	logic                             sat_q, at_max;

	// byte classes
	logic        is_space, is_punct;
	ctt_pkg::kind_t pk;

	// idle handling of a byte
	ctt_pkg::mode_t                  idle_mode;
	logic [ctt_pkg::OFFSET_BITS-1:0] idle_pend;

	ctt_pkg::tok_t name_tok, punct_tok, end_tok;
	logic [1:0]    nres;
	logic          quoted_mode;

	// character classes
	always_comb begin
		is_space = (byte_value == ctt_pkg::CH_SPACE) || (byte_value == ctt_pkg::CH_CR) ||
			(byte_value == ctt_pkg::CH_TAB) || (byte_value == ctt_pkg::CH_LF);
		unique case (byte_value)
			ctt_pkg::CH_LBRACE: pk = ctt_pkg::KIND_BLOCK_OPEN;
			ctt_pkg::CH_RBRACE: pk = ctt_pkg::KIND_BLOCK_CLOSE;
			ctt_pkg::CH_LBRACK: pk = ctt_pkg::KIND_LIST_OPEN;
			ctt_pkg::CH_RBRACK: pk = ctt_pkg::KIND_LIST_CLOSE;
			ctt_pkg::CH_COLON:  pk = ctt_pkg::KIND_COLON;
			ctt_pkg::CH_COMMA:  pk = ctt_pkg::KIND_COMMA;
			default:            pk = ctt_pkg::KIND_END;
		endcase
		is_punct = (pk != ctt_pkg::KIND_END);
	end

	// position bookkeeping; the pending start never passes the position
	assign at_max = (pos_q == ctt_pkg::POS_MAX);
	assign nxt    = at_max ? pos_q : pos_q + 1'b1;
	assign span   = pos_q - pend_q;

	assign quoted_mode = (mode_q == ctt_pkg::MODE_STRING) || (mode_q == ctt_pkg::MODE_STR_ESC);

	always_comb begin
		name_tok.kind    = ctt_pkg::KIND_IDENT;
		name_tok.start   = ctt_pkg::FIELD_W'(pend_q);
		name_tok.len     = ctt_pkg::FIELD_W'(span);
		name_tok.quoted  = quoted_mode;
		punct_tok.kind   = pk;
		punct_tok.start  = ctt_pkg::FIELD_W'(pos_q);
		punct_tok.len    = ctt_pkg::FIELD_W'(1);
		punct_tok.quoted = 1'b0;
		end_tok.kind     = ctt_pkg::KIND_END;
		end_tok.start    = ctt_pkg::FIELD_W'(pos_q);
		end_tok.len      = '0;
		end_tok.quoted   = 1'b0;
	end

	// byte seen between tokens
	always_comb begin
		idle_pend = pos_q;
		if (is_space || is_punct) begin
			idle_mode = ctt_pkg::MODE_IDLE;
		end else if (byte_value == ctt_pkg::CH_QUOTE) begin
			idle_mode = ctt_pkg::MODE_STRING;
			idle_pend = nxt;
		end else if (byte_value == ctt_pkg::CH_DASH) begin
			idle_mode = ctt_pkg::MODE_DASH;
		end else begin
			idle_mode = ctt_pkg::MODE_IDENT;
		end
	end

	// mode machine: next mode and emitted tokens
	always_comb begin
		mode_d = mode_q;
		pend_d = pend_q;
		nres   = 2'd0;
		rec.t0 = name_tok;
		rec.t1 = punct_tok;
		if (end_marker) begin
			mode_d = ctt_pkg::MODE_IDLE;
			pend_d = '0;
			unique case (mode_q)
				ctt_pkg::MODE_DASH, ctt_pkg::MODE_IDENT,
				ctt_pkg::MODE_STRING, ctt_pkg::MODE_STR_ESC: begin
					rec.t1 = end_tok;
					nres   = 2'd2;
				end
				default: begin
					rec.t0 = end_tok;
					nres   = 2'd1;
				end
			endcase
		end else begin
			unique case (mode_q)
				ctt_pkg::MODE_DASH: begin
					if (byte_value == ctt_pkg::CH_DASH) begin
						mode_d = ctt_pkg::MODE_DASH2;
					end else if (is_space || is_punct) begin
						mode_d = ctt_pkg::MODE_IDLE;
						nres   = is_punct ? 2'd2 : 2'd1;
					end else begin
						mode_d = ctt_pkg::MODE_IDENT;
					end
				end
				ctt_pkg::MODE_DASH2: begin
					if (byte_value == ctt_pkg::CH_LF)
						mode_d = ctt_pkg::MODE_IDLE;
					else if (byte_value == ctt_pkg::CH_LBRACK)
						mode_d = ctt_pkg::MODE_DASH2_BR;
					else
						mode_d = ctt_pkg::MODE_LINE;
				end
				ctt_pkg::MODE_DASH2_BR: begin
					if (byte_value == ctt_pkg::CH_LF)
						mode_d = ctt_pkg::MODE_IDLE;
					else if (byte_value == ctt_pkg::CH_LBRACK)
						mode_d = ctt_pkg::MODE_BLOCK;
					else
						mode_d = ctt_pkg::MODE_LINE;
				end
				ctt_pkg::MODE_LINE: begin
					if (byte_value == ctt_pkg::CH_LF)
						mode_d = ctt_pkg::MODE_IDLE;
				end
				ctt_pkg::MODE_BLOCK: begin
					if (byte_value == ctt_pkg::CH_RBRACK)
						mode_d = ctt_pkg::MODE_BLOCK_BR;
				end
				ctt_pkg::MODE_BLOCK_BR: begin
					mode_d = (byte_value == ctt_pkg::CH_RBRACK) ? ctt_pkg::MODE_IDLE :
						ctt_pkg::MODE_BLOCK;
				end
				ctt_pkg::MODE_IDENT: begin
					if (is_space || is_punct) begin
						mode_d = ctt_pkg::MODE_IDLE;
						nres   = is_punct ? 2'd2 : 2'd1;
					end
				end
				ctt_pkg::MODE_STRING: begin
					if (byte_value == ctt_pkg::CH_BSLASH) begin
						mode_d = ctt_pkg::MODE_STR_ESC;
					end else if (byte_value == ctt_pkg::CH_QUOTE) begin
						mode_d = ctt_pkg::MODE_IDLE;
						nres   = 2'd1;
					end
				end
				ctt_pkg::MODE_STR_ESC: begin
					mode_d = ctt_pkg::MODE_STRING;
				end
				default: begin
					// idle, and codes no transition produces
					mode_d = idle_mode;
					pend_d = idle_pend;
					rec.t0 = punct_tok;
					nres   = is_punct ? 2'd1 : 2'd0;
				end
			endcase
		end
		rec.two = (nres == 2'd2);
		rec.ovf = end_marker ? sat_q : (sat_q | at_max);
	end

	assign rec_valid = take && (nres != 2'd0);

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ctt_pkg::MODE_IDLE;
			pos_q  <= '0;
			pend_q <= '0;
			sat_q  <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			if (end_marker) begin
				pos_q <= '0;
				sat_q <= 1'b0;
			end else begin
				pos_q <= nxt;
				sat_q <= sat_q | at_max;
			end
		end
	end

endmodule

// File: hdl/ctt_fifo.sv
`timescale 1ns / 1ps
// Short queue of token records between scanner and output stage.
// Depends on ctt_pkg for the record type and depth; head entry read ahead.

module ctt_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  ctt_pkg::rec_t      wr_data,
	input  logic               rd_en,
	output ctt_pkg::rec_t      rd_data,
	output ctt_pkg::q_stat_t   stat
);

	ctt_pkg::rec_t                  mem_q [ctt_pkg::FIFO_DEPTH];
	logic [ctt_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ctt_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                           do_wr, do_rd;

	localparam logic [ctt_pkg::FIFO_PTR_W-1:0] PTR_LAST =
		ctt_pkg::FIFO_PTR_W'(ctt_pkg::FIFO_DEPTH - 1);
	localparam logic [ctt_pkg::FIFO_CNT_W-1:0] CNT_FULL =
		ctt_pkg::FIFO_CNT_W'(ctt_pkg::FIFO_DEPTH);

	assign stat.full  = (cnt_q == CNT_FULL);
	assign stat.empty = (cnt_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hdl/ctt_back.sv
`timescale 1ns / 1ps
// Output stage: takes token records from the queue and hands out one token
// per request. Depends on ctt_pkg.

module ctt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ctt_pkg::rec_t      rd_data,
	input  ctt_pkg::q_stat_t   stat,
	output logic               rd_en,
	input  logic               pop,
	output logic               empty,
	output logic [2:0]         token_kind,
	output logic [23:0]        token_start,
	output logic [23:0]        token_length,
	output logic               quoted,
	output logic               offset_overflow,
	output logic               last_of_run
);

	ctt_pkg::rec_t cur_q;
	ctt_pkg::tok_t tok;
	logic          vld_q, idx_q;
	logic          give, done;

	assign give  = pop && vld_q;
	assign done  = give && (idx_q || !cur_q.two);
	assign rd_en = (!vld_q || done) && !stat.empty;

	// held record
	always_ff @(posedge clk) begin
		if (rd_en)
			cur_q <= rd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 1'b0;
		end else if (rd_en) begin
			vld_q <= 1'b1;
			idx_q <= 1'b0;
		end else if (done) begin
			vld_q <= 1'b0;
			idx_q <= 1'b0;
		end else if (give) begin
			idx_q <= 1'b1;
		end
	end

	// token select
	assign tok             = idx_q ? cur_q.t1 : cur_q.t0;
	assign empty           = !vld_q;
	assign token_kind      = tok.kind;
	assign token_start     = tok.start;
	assign token_length    = tok.len;
	assign quoted          = tok.quoted;
	assign offset_overflow = cur_q.ovf;
	assign last_of_run     = idx_q || !cur_q.two;

endmodule

// File: hdl/ctt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the tokenizer, attached to the top level by bind.
// Depends on ctt_pkg for the token kind codes.

module ctt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  token_kind,
	input logic [23:0] token_length,
	input logic        quoted,
	input logic        last_of_run
);

	// second token of an item follows right after the first is taken
	a_second_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_of_run) |=> !empty)
		else $error("second token of an item not presented");

	// end token is the last one of its item and has no length
	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind == ctt_pkg::KIND_END) |-> (last_of_run && token_length == '0))
		else $error("malformed end token");

	// only names can be quoted
	a_quoted_name: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && quoted) |-> (token_kind == ctt_pkg::KIND_IDENT))
		else $error("quoted token that is not a name");

	// punctuation is one byte long
	a_punct_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind != ctt_pkg::KIND_END && token_kind != ctt_pkg::KIND_IDENT)
		|-> (token_length == 24'd1))
		else $error("punctuation token length not one");

	// a waiting token holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(token_kind) && $stable(last_of_run)))
		else $error("waiting token changed");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.token_kind   (token_kind),
	.token_length (token_length),
	.quoted       (quoted),
	.last_of_run  (last_of_run)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for config_text_tokenizer: directed and random sources,
// with a scoreboard class that predicts every token and checks each one popped.
// Depends on ctt_pkg (kinds, modes, character codes, widths) and the tokenizer RTL.

// One expected token as it should show on the result ports
typedef struct packed {
	ctt_pkg::kind_t              kind;
	logic [ctt_pkg::FIELD_W-1:0] start;
	logic [ctt_pkg::FIELD_W-1:0] len;
	logic                        quoted;
	logic                        ovf;
	logic                        last;
} token_exp_t;

class token_scoreboard;
	token_exp_t                      due_tokens[$];
	token_exp_t                      item_tokens[$];
	ctt_pkg::mode_t                  scan_mode;
	logic [ctt_pkg::OFFSET_BITS-1:0] src_pos;
	logic [ctt_pkg::OFFSET_BITS-1:0] tok_start;
	logic                            sat;
	int                              failures;

	function new();
		clear_source();
		failures = 0;
	endfunction

	function void clear_source();
		scan_mode = ctt_pkg::MODE_IDLE;
		src_pos = '0;
		tok_start = '0;
		sat = 1'b0;
	endfunction

	function int pending();
		return due_tokens.size();
	endfunction

	function logic [ctt_pkg::FIELD_W-1:0] span(logic [ctt_pkg::OFFSET_BITS-1:0] from,
			logic [ctt_pkg::OFFSET_BITS-1:0] to);
		return (to >= from) ? ctt_pkg::FIELD_W'(to - from) : '0;
	endfunction

	function void add_tok(ctt_pkg::kind_t kind, logic [ctt_pkg::OFFSET_BITS-1:0] start,
			logic [ctt_pkg::FIELD_W-1:0] len, logic q);
		token_exp_t t;
		t.kind = kind;
		t.start = ctt_pkg::FIELD_W'(start);
		t.len = len;
		t.quoted = q;
		t.ovf = sat;
		t.last = 1'b0;
		item_tokens.push_back(t);
	endfunction

	// KIND_END means "not a punctuation mark"
	function ctt_pkg::kind_t punct_of(logic [7:0] c);
		case (c)
			ctt_pkg::CH_LBRACE: return ctt_pkg::KIND_BLOCK_OPEN;
			ctt_pkg::CH_RBRACE: return ctt_pkg::KIND_BLOCK_CLOSE;
			ctt_pkg::CH_LBRACK: return ctt_pkg::KIND_LIST_OPEN;
			ctt_pkg::CH_RBRACK: return ctt_pkg::KIND_LIST_CLOSE;
			ctt_pkg::CH_COLON:  return ctt_pkg::KIND_COLON;
			ctt_pkg::CH_COMMA:  return ctt_pkg::KIND_COMMA;
			default:            return ctt_pkg::KIND_END;
		endcase
	endfunction

	function logic is_blank(logic [7:0] c);
		return c == ctt_pkg::CH_SPACE || c == ctt_pkg::CH_CR || c == ctt_pkg::CH_TAB ||
			c == ctt_pkg::CH_LF;
	endfunction

	function logic breaks_ident(logic [7:0] c);
		return is_blank(c) || punct_of(c) != ctt_pkg::KIND_END;
	endfunction

	// Byte seen between tokens
	function void start_token(logic [7:0] c, logic [ctt_pkg::OFFSET_BITS-1:0] off,
			logic [ctt_pkg::OFFSET_BITS-1:0] nxt);
		ctt_pkg::kind_t k;
		k = punct_of(c);
		if (is_blank(c)) begin
			scan_mode = ctt_pkg::MODE_IDLE;
		end else if (k != ctt_pkg::KIND_END) begin
			add_tok(k, off, ctt_pkg::FIELD_W'(1), 1'b0);
			scan_mode = ctt_pkg::MODE_IDLE;
		end else if (c == ctt_pkg::CH_QUOTE) begin
			tok_start = nxt;
			scan_mode = ctt_pkg::MODE_STRING;
		end else if (c == ctt_pkg::CH_DASH) begin
			tok_start = off;
			scan_mode = ctt_pkg::MODE_DASH;
		end else begin
			tok_start = off;
			scan_mode = ctt_pkg::MODE_IDENT;
		end
	endfunction

	// Work out the tokens that one accepted request causes
	function void predict_tokens(logic [7:0] c, logic fin);
		logic [ctt_pkg::OFFSET_BITS-1:0] off;
		logic [ctt_pkg::OFFSET_BITS-1:0] nxt;
		item_tokens.delete();
		if (fin) begin
			// flush the open token, then the end token; next source starts at 0
			if (scan_mode == ctt_pkg::MODE_DASH || scan_mode == ctt_pkg::MODE_IDENT)
				add_tok(ctt_pkg::KIND_IDENT, tok_start, span(tok_start, src_pos), 1'b0);
			else if (scan_mode == ctt_pkg::MODE_STRING || scan_mode == ctt_pkg::MODE_STR_ESC)
				add_tok(ctt_pkg::KIND_IDENT, tok_start, span(tok_start, src_pos), 1'b1);
			add_tok(ctt_pkg::KIND_END, src_pos, '0, 1'b0);
			clear_source();
		end else begin
			off = src_pos;
			if (off == ctt_pkg::POS_MAX) begin
				sat = 1'b1;
				nxt = off;
			end else begin
				nxt = off + 1'b1;
			end
			src_pos = nxt;
			case (scan_mode)
				ctt_pkg::MODE_DASH: begin
					if (c == ctt_pkg::CH_DASH) begin
						scan_mode = ctt_pkg::MODE_DASH2;
					end else if (breaks_ident(c)) begin
						add_tok(ctt_pkg::KIND_IDENT, tok_start, span(tok_start, off), 1'b0);
						start_token(c, off, nxt);
					end else begin
						scan_mode = ctt_pkg::MODE_IDENT;
					end
				end
				ctt_pkg::MODE_DASH2:
					scan_mode = (c == ctt_pkg::CH_LF) ? ctt_pkg::MODE_IDLE :
						((c == ctt_pkg::CH_LBRACK) ? ctt_pkg::MODE_DASH2_BR :
						ctt_pkg::MODE_LINE);
				ctt_pkg::MODE_DASH2_BR:
					scan_mode = (c == ctt_pkg::CH_LF) ? ctt_pkg::MODE_IDLE :
						((c == ctt_pkg::CH_LBRACK) ? ctt_pkg::MODE_BLOCK :
						ctt_pkg::MODE_LINE);
				ctt_pkg::MODE_LINE:
					scan_mode = (c == ctt_pkg::CH_LF) ? ctt_pkg::MODE_IDLE :
						ctt_pkg::MODE_LINE;
				ctt_pkg::MODE_BLOCK:
					scan_mode = (c == ctt_pkg::CH_RBRACK) ? ctt_pkg::MODE_BLOCK_BR :
						ctt_pkg::MODE_BLOCK;
				ctt_pkg::MODE_BLOCK_BR:
					scan_mode = (c == ctt_pkg::CH_RBRACK) ? ctt_pkg::MODE_IDLE :
						ctt_pkg::MODE_BLOCK;
				ctt_pkg::MODE_IDENT: begin
					if (breaks_ident(c)) begin
						add_tok(ctt_pkg::KIND_IDENT, tok_start, span(tok_start, off), 1'b0);
						start_token(c, off, nxt);
					end
				end
				ctt_pkg::MODE_STRING: begin
					if (c == ctt_pkg::CH_BSLASH) begin
						scan_mode = ctt_pkg::MODE_STR_ESC;
					end else if (c == ctt_pkg::CH_QUOTE) begin
						add_tok(ctt_pkg::KIND_IDENT, tok_start, span(tok_start, off), 1'b1);
						scan_mode = ctt_pkg::MODE_IDLE;
					end
				end
				ctt_pkg::MODE_STR_ESC: scan_mode = ctt_pkg::MODE_STRING;
				default:               start_token(c, off, nxt);
			endcase
		end
		if (item_tokens.size() > 0)
			item_tokens[item_tokens.size() - 1].last = 1'b1;
		foreach (item_tokens[i])
			due_tokens.push_back(item_tokens[i]);
	endfunction

	function void compare_field(string name, logic [ctt_pkg::FIELD_W-1:0] want,
			logic [ctt_pkg::FIELD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	// Check one popped token against the oldest expectation
	function void check_token(logic [2:0] kind, logic [ctt_pkg::FIELD_W-1:0] start,
			logic [ctt_pkg::FIELD_W-1:0] len, logic q, logic ovf, logic last);
		token_exp_t e;
		if (due_tokens.size() == 0) begin
			$error("token with none expected: kind %0d start %0d length %0d", kind, start, len);
			failures++;
			return;
		end
		e = due_tokens.pop_front();
		compare_field("token_kind", ctt_pkg::FIELD_W'(e.kind), ctt_pkg::FIELD_W'(kind));
		compare_field("token_start", e.start, start);
		compare_field("token_length", e.len, len);
		compare_field("quoted", ctt_pkg::FIELD_W'(e.quoted), ctt_pkg::FIELD_W'(q));
		compare_field("offset_overflow", ctt_pkg::FIELD_W'(e.ovf), ctt_pkg::FIELD_W'(ovf));
		compare_field("last_of_run", ctt_pkg::FIELD_W'(e.last), ctt_pkg::FIELD_W'(last));
	endfunction
endclass

module testbench;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 1700;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  byte_value = 8'h00;
	logic        end_marker = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  token_kind;
	logic [23:0] token_start;
	logic [23:0] token_length;
	logic        quoted;
	logic        offset_overflow;
	logic        last_of_run;

	token_scoreboard scoreboard;
	int          send_idle_pct = 8;
	int          recv_idle_pct = 55;
	int          items_sent = 0;
	int unsigned cycle_count = 0;

	logic [7:0] punct_chars [6] = '{ctt_pkg::CH_LBRACE, ctt_pkg::CH_RBRACE,
		ctt_pkg::CH_LBRACK, ctt_pkg::CH_RBRACK, ctt_pkg::CH_COLON, ctt_pkg::CH_COMMA};
	logic [7:0] blank_chars [4] = '{ctt_pkg::CH_SPACE, ctt_pkg::CH_CR, ctt_pkg::CH_TAB,
		ctt_pkg::CH_LF};

	config_text_tokenizer uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.byte_value      (byte_value),
		.end_marker      (end_marker),
		.empty           (empty),
		.pop             (pop),
		.token_kind      (token_kind),
		.token_start     (token_start),
		.token_length    (token_length),
		.quoted          (quoted),
		.offset_overflow (offset_overflow),
		.last_of_run     (last_of_run)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side: random pop, check on every accepted pop
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			scoreboard.check_token(token_kind, token_start, token_length, quoted,
				offset_overflow, last_of_run);
	end

	// One request; entered and left at a falling edge
	task automatic send_item(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		byte_value <= c;
		end_marker <= fin;
		do @(posedge clk); while (full);
		scoreboard.predict_tokens(c, fin);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_item(c, 1'b0);
	endtask

	task automatic send_end();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Sender holds off until every predicted token has been popped
	task automatic wait_drained();
		push <= 1'b0;
		do @(negedge clk); while (scoreboard.pending() != 0);
	endtask

	function automatic logic [7:0] separator();
		return ($urandom_range(1) == 0) ? blank_chars[$urandom_range(3)] :
			punct_chars[$urandom_range(5)];
	endfunction

	// A small source built mostly from well-formed fragments, ended by the end marker
	task automatic send_random_source();
		int n_frag;
		int n;
		int k;
		n_frag = $urandom_range(24, 1);
		for (int f = 0; f < n_frag; f++) begin
			case ($urandom_range(11))
				0, 1: send_byte(punct_chars[$urandom_range(5)]);
				2, 3: begin
					// identifier, now and then with a quote, a dash or any byte inside
					n = $urandom_range(6, 1);
					repeat (n) begin
						k = $urandom_range(9);
						send_byte((k == 0) ? ctt_pkg::CH_QUOTE : (k == 1) ? ctt_pkg::CH_DASH :
							(k == 2) ? 8'($urandom_range(255)) :
							8'h61 + 8'($urandom_range(25)));
					end
					send_byte(separator());
				end
				4: begin
					// quoted string with raw escapes, sometimes left open
					send_byte(ctt_pkg::CH_QUOTE);
					n = $urandom_range(8);
					repeat (n) begin
						if ($urandom_range(4) == 0)
							send_byte(ctt_pkg::CH_BSLASH);
						send_byte(8'($urandom_range(255)));
					end
					if ($urandom_range(9) != 0)
						send_byte(ctt_pkg::CH_QUOTE);
				end
				5: send_byte(blank_chars[$urandom_range(3)]);
				6: begin
					send_text("--");
					n = $urandom_range(6);
					repeat (n) send_byte(8'($urandom_range(255)));
					send_byte(ctt_pkg::CH_LF);
				end
				7: begin
					// block comment, brackets inside, sometimes left open
					send_text("--[[");
					n = $urandom_range(8);
					repeat (n)
						send_byte(($urandom_range(3) == 0) ? ctt_pkg::CH_RBRACK :
							8'($urandom_range(255)));
					if ($urandom_range(9) != 0)
						send_text("]]");
				end
				8: begin
					// one bracket short of a block comment
					send_text("--[");
					n = $urandom_range(4);
					repeat (n) send_byte(8'h61 + 8'($urandom_range(25)));
					send_byte(ctt_pkg::CH_LF);
				end
				9: begin
					send_byte(ctt_pkg::CH_DASH);
					send_byte(separator());
				end
				default: send_byte(8'($urandom_range(255)));
			endcase
		end
		send_end();
	endtask

	initial begin
		scoreboard = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// lone dash before a comma, every punctuation mark, quote inside an
		// identifier, string with an escaped quote
		send_text("-,{}[]:");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(ctt_pkg::CH_QUOTE);
		send_text("\t\"\\\"\"");
		send_end();
		// line comment that nearly opened a block, then a dash pair as the last bytes
		send_text("--[x\n--");
		send_end();
		// string still open at the end
		send_text("\"ab");
		send_end();
		wait_drained();

		// three idle profiles, draining between them
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 55 : 0;
			recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 8 : 0;
			while (items_sent < ITEM_TARGET * (phase + 1) / 3)
				send_random_source();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (scoreboard.failures == 0 && scoreboard.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// File: files.f
hdl/ctt_pkg.sv
hdl/ctt_front.sv
hdl/ctt_fifo.sv
hdl/ctt_back.sv
hdl/config_text_tokenizer.sv
hdl/ctt_checker.sv
tb/testbench.sv
